// File: rtl/int8_dot_product_requantize_defines.svh
// assertion helpers used by the top-level rtl module
`ifndef INT8_DOT_PRODUCT_REQUANTIZE_DEFINES_SVH
`define INT8_DOT_PRODUCT_REQUANTIZE_DEFINES_SVH

// same-cycle implication
`define DPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpr same-cycle check failed");

// next-cycle implication
`define DPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpr next-cycle check failed");

`endif

// File: rtl/dpr_pkg.sv
package dpr_pkg;

   localparam int ACT_W   = 8;
   localparam int WGT_W   = 8;
   localparam int WORD_W  = 32;
   localparam int WORK_W  = 2 * WORD_W;
   localparam int SHIFT_W = 6;
   localparam int RES_W   = 8;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int OUT_MAX = 127;
   localparam int OUT_MIN = -128;

   // csr map, byte address is 4 * index
   localparam int REG_COUNT = 4;

   typedef enum logic [1:0] {
      REG_SCALE_MULT,
      REG_SCALE_SHIFT,
      REG_OUT_OFFSET,
      REG_RELU_ENABLE
   } reg_index_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_ADD,
      ALU_ASR
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic [WORK_W-1:0]   opa;
      logic [WORK_W-1:0]   opb;
   } alu_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   scale_mult;
      logic [SHIFT_W-1:0]  scale_shift;
      logic [WORD_W-1:0]   out_offset;
      logic                relu_enable;
   } cfg_type;

endpackage

// File: rtl/dpr_req_if.sv
interface dpr_req_if;
   import dpr_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    activation;
   logic [WGT_W-1:0]    weight;
   logic [WORD_W-1:0]   bias;
   logic                last_pair;

   modport source (output valid, output activation, output weight, output bias,
                   output last_pair, input ready);
   modport sink   (input valid, input activation, input weight, input bias,
                   input last_pair, output ready);
endinterface

// File: rtl/dpr_rsp_if.sv
interface dpr_rsp_if;
   import dpr_pkg::*;

   logic              valid;
   logic              ready;
   logic [RES_W-1:0]  result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

// File: rtl/dpr_alu.sv
module dpr_alu (
   input  dpr_pkg::alu_req_type          alu_req,
   output logic [dpr_pkg::WORK_W-1:0]    alu_res
);
   import dpr_pkg::*;

   logic signed [WORD_W-1:0]  mul_a;
   logic signed [WORD_W-1:0]  mul_b;
   logic signed [WORK_W-1:0]  mul_p;
   logic signed [WORK_W-1:0]  add_a;
   logic signed [WORK_W-1:0]  add_b;

   // 32x32 signed multiply, exact sign-extended add, 64-bit arithmetic shift
   always_comb begin
      mul_a = alu_req.opa[WORD_W-1:0];
      mul_b = alu_req.opb[WORD_W-1:0];
      mul_p = mul_a * mul_b;
      add_a = {{WORD_W{alu_req.opa[WORD_W-1]}}, alu_req.opa[WORD_W-1:0]};
      add_b = {{WORD_W{alu_req.opb[WORD_W-1]}}, alu_req.opb[WORD_W-1:0]};
      case (alu_req.op)
         ALU_MUL: alu_res = mul_p;
         ALU_ADD: alu_res = add_a + add_b;
         ALU_ASR: alu_res = $signed(alu_req.opa) >>> alu_req.opb[SHIFT_W-1:0];
         default: alu_res = '0;
      endcase
   end
endmodule

// File: rtl/dpr_csr.sv
module dpr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dpr_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [dpr_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [dpr_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output dpr_pkg::cfg_type              cfg
);
   import dpr_pkg::*;

   cfg_type        cfg_ff;
   cfg_type        cfg_in;
   reg_index_type  reg_sel;
   logic           wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SCALE_MULT:  cfg_in.scale_mult  = csr_pwdata[WORD_W-1:0];
            REG_SCALE_SHIFT: cfg_in.scale_shift = csr_pwdata[SHIFT_W-1:0];
            REG_OUT_OFFSET:  cfg_in.out_offset  = csr_pwdata[WORD_W-1:0];
            REG_RELU_ENABLE: cfg_in.relu_enable = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SCALE_MULT:  csr_prdata = cfg_ff.scale_mult;
         REG_SCALE_SHIFT: csr_prdata = {{(DATA_W-SHIFT_W){1'b0}}, cfg_ff.scale_shift};
         REG_OUT_OFFSET:  csr_prdata = cfg_ff.out_offset;
         REG_RELU_ENABLE: csr_prdata = {{(DATA_W-1){1'b0}}, cfg_ff.relu_enable};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// File: rtl/int8_dot_product_requantize.sv
// int8 dot product with requantization, one neuron at a time
// req_chan (valid/ready) carries activation, weight, bias and last_pair; every
// transfer adds activation*weight into a 32-bit wrapping accumulator.
// a transfer with last_pair set also adds bias, scales by scale_mult, shifts
// right by scale_shift, applies relu if enabled, adds out_offset and clamps to
// -128..127; that 8-bit value is one transfer on rsp_chan.
// all arithmetic goes through one shared unit (32x32 multiply, add, 64-bit
// shift) under a small sequencer, one operation per cycle, and req_chan.ready
// is high only while the sequencer is idle and out of reset.
// a pair without last_pair passes the accept, multiply and accumulate steps;
// a pair with last_pair also passes the bias, scale, shift and offset steps,
// and the offset step writes its result to the output register for rsp_chan.
// the result sits in an output register, so the next pair is taken while it
// waits; if rsp_chan stalls and a second result is ready, the sequencer holds
// in its offset step until the register frees up.
// csr port: apb-style writes, pready tied high; registers at byte offsets 0
// (scale_mult), 4 (scale_shift), 8 (out_offset), 12 (relu_enable).
// synchronous reset clears the accumulator, configuration and output valid.
`include "int8_dot_product_requantize_defines.svh"

module int8_dot_product_requantize (
   input  logic                          clock,
   input  logic                          reset,
   dpr_req_if.sink                       req_chan,
   dpr_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dpr_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [dpr_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [dpr_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import dpr_pkg::*;

   localparam int SUM_W = WORD_W + 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(OUT_MAX);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(OUT_MIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_BIAS,
      ST_SCALE,
      ST_SHIFT,
      ST_OFFSET
   } state_type;

   cfg_type                   cfg;
   alu_req_type               alu_req;
   logic [WORK_W-1:0]         alu_res;

   state_type                 state_ff, state_in;
   logic [WORD_W-1:0]         acc_ff, acc_in;
   logic [WORK_W-1:0]         work_ff, work_in;
   logic [ACT_W-1:0]          act_ff, act_in;
   logic [WGT_W-1:0]          wgt_ff, wgt_in;
   logic [WORD_W-1:0]         bias_ff, bias_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]          rsp_result_ff, rsp_result_in;

   logic                      req_xfer;
   logic                      out_free;
   logic signed [SUM_W-1:0]   sum;

   dpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // the one shared arithmetic unit
   dpr_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   assign req_chan.ready  = (state_ff == ST_IDLE) && !reset;
   assign req_xfer        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;

   // output register can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // exact 33-bit offset sum out of the unit
   assign sum      = alu_res[SUM_W-1:0];

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      work_in       = work_ff;
      act_in        = act_ff;
      wgt_in        = wgt_ff;
      bias_in       = bias_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_result_in = rsp_result_ff;
      alu_req.op    = ALU_ADD;
      alu_req.opa   = {{WORD_W{1'b0}}, acc_ff};
      alu_req.opb   = {{WORD_W{1'b0}}, work_ff[WORD_W-1:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               act_in   = req_chan.activation;
               wgt_in   = req_chan.weight;
               bias_in  = req_chan.bias;
               last_in  = req_chan.last_pair;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // activation * weight, both sign extended
            alu_req.op  = ALU_MUL;
            alu_req.opa = {{(WORK_W-ACT_W){act_ff[ACT_W-1]}}, act_ff};
            alu_req.opb = {{(WORK_W-WGT_W){wgt_ff[WGT_W-1]}}, wgt_ff};
            work_in     = alu_res;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            // wrapping accumulate: keep the low word
            acc_in   = alu_res[WORD_W-1:0];
            state_in = last_ff ? ST_BIAS : ST_IDLE;
         end
         ST_BIAS: begin
            alu_req.opb = {{WORD_W{1'b0}}, bias_ff};
            work_in     = {{WORD_W{alu_res[WORD_W-1]}}, alu_res[WORD_W-1:0]};
            acc_in      = '0;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            alu_req.op  = ALU_MUL;
            alu_req.opa = work_ff;
            alu_req.opb = {{WORD_W{1'b0}}, cfg.scale_mult};
            work_in     = alu_res;
            state_in    = ST_SHIFT;
         end
         ST_SHIFT: begin
            // shift, keep low word as signed, then optional relu
            alu_req.op  = ALU_ASR;
            alu_req.opa = work_ff;
            alu_req.opb = {{(WORK_W-SHIFT_W){1'b0}}, cfg.scale_shift};
            if (cfg.relu_enable && alu_res[WORD_W-1]) begin
               work_in = '0;
            end else begin
               work_in = {{WORD_W{alu_res[WORD_W-1]}}, alu_res[WORD_W-1:0]};
            end
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            alu_req.opa = work_ff;
            alu_req.opb = {{WORD_W{1'b0}}, cfg.out_offset};
            if (out_free) begin
               if (sum > SUM_MAX) begin
                  rsp_result_in = RES_W'(OUT_MAX);
               end else if (sum < SUM_MIN) begin
                  rsp_result_in = RES_W'(OUT_MIN);
               end else begin
                  rsp_result_in = sum[RES_W-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      act_ff        <= act_in;
      wgt_ff        <= wgt_in;
      bias_ff       <= bias_in;
      last_ff       <= last_in;
      rsp_result_ff <= rsp_result_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // accumulator is empty once a neuron's bias step is done
   `DPR_ASSERT_NEXT(a_acc_clear, clock, reset, state_ff == ST_BIAS, acc_ff == '0)
   // a new result only comes from the offset step
   `DPR_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OFFSET)
   // relu leaves no negative value for the offset step
   `DPR_ASSERT_IMPLY(a_relu_clean, clock, reset, state_ff == ST_OFFSET && cfg.relu_enable, !work_ff[WORD_W-1])

endmodule

// File: tb/tb_int8_dot_product_requantize.sv
module tb_int8_dot_product_requantize;
   import dpr_pkg::*;

   // run limits, in clock cycles
   localparam int SETTLE_CYCLES  = 12;    // lets a pair still in the sequencer finish
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either channel
   localparam int HOLD_CYCLES    = 150;   // long output stall, fills the block
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_PAIRS    = 125;

   // output side stall behavior
   typedef enum int {
      SINK_OPEN,
      SINK_RANDOM,
      SINK_SPARSE
   } sink_mode_type;

   // one activation/weight pair as the sender sees it
   typedef struct {
      logic signed [ACT_W-1:0]  activation;
      logic signed [WGT_W-1:0]  weight;
      logic [WORD_W-1:0]        bias;
      logic                     last_pair;
   } mac_pair_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_W-1:0]    csr_paddr;
   logic [DATA_W-1:0]    csr_pwdata;
   logic [DATA_W-1:0]    csr_prdata;
   logic                 csr_pready;

   dpr_req_if req_if();
   dpr_rsp_if rsp_if();

   int8_dot_product_requantize dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state: mirrored registers and the running sum
   cfg_type                   model_cfg;
   logic [WORD_W-1:0]         running_sum = '0;

   // pairs waiting for the driver, neuron outputs waiting for the monitor
   mac_pair_type              pairs_to_send[$];
   logic signed [RES_W-1:0]   neuron_outputs_due[$];

   // driver state
   mac_pair_type              bus_pair;
   logic                      pair_on_bus = 1'b0;
   int                        burst_left = 0;
   int                        gap_left = 0;

   // monitor state
   sink_mode_type             sink_mode = SINK_OPEN;
   int                        mode_left = 0;
   int                        hold_left = 0;
   logic                      sink_take;
   logic signed [RES_W-1:0]   output_wanted;

   // bookkeeping
   int                        mismatches = 0;
   int                        pairs_accepted = 0;
   int                        outputs_checked = 0;
   int                        settings_applied = 0;
   int                        long_holds = 0;
   int                        quiet_cycles = 0;

   // clock, period 20
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // requantize a finished sum with the mirrored registers
   function automatic logic signed [RES_W-1:0] requantize(logic signed [WORD_W-1:0] total);
      longint wide;
      longint kept;
      longint level;
      wide = longint'(total) * longint'($signed(model_cfg.scale_mult));
      wide = wide >>> model_cfg.scale_shift;
      // keep only the low word, read back as two's complement
      kept = longint'($signed(wide[WORD_W-1:0]));
      if (model_cfg.relu_enable && kept < 0)
         kept = 0;
      // offset add is exact, no wrap before the clamp
      level = kept + longint'($signed(model_cfg.out_offset));
      if (level > OUT_MAX)
         level = OUT_MAX;
      else if (level < OUT_MIN)
         level = OUT_MIN;
      return level[RES_W-1:0];
   endfunction

   // one accepted pair: accumulate with wrap, close the neuron on the last pair
   function automatic void mac_step(mac_pair_type p);
      logic [WORD_W-1:0] total;
      running_sum = running_sum + WORD_W'(int'(p.activation) * int'(p.weight));
      if (p.last_pair) begin
         total = running_sum + p.bias;
         running_sum = '0;
         neuron_outputs_due.push_back(requantize(total));
      end
   endfunction

   // random int8 with the extremes weighted up
   function automatic logic signed [7:0] pick_int8();
      case ($urandom_range(0, 7))
         0: return -8'sd128;
         1: return 8'sd127;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_pair(input logic signed [7:0] a, input logic signed [7:0] w,
                           input logic [WORD_W-1:0] b, input logic last);
      mac_pair_type p;
      p.activation = a;
      p.weight     = w;
      p.bias       = b;
      p.last_pair  = last;
      pairs_to_send.push_back(p);
   endtask

   // apb write: setup cycle, then access until pready
   task automatic csr_write(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input reg_index_type idx, output logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'(4 * int'(idx));
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // block is idle once nothing is queued, offered or owed, plus settle time
   task automatic wait_idle();
      while (pairs_to_send.size() != 0 || pair_on_bus || neuron_outputs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers while idle, mirror them, read them back
   task automatic apply_settings(input logic [WORD_W-1:0] mult, input logic [SHIFT_W-1:0] shift,
                                 input logic [WORD_W-1:0] offset, input logic relu);
      logic [DATA_W-1:0] reg_value[REG_COUNT];
      logic [DATA_W-1:0] got;
      wait_idle();
      reg_value[REG_SCALE_MULT]  = mult;
      reg_value[REG_SCALE_SHIFT] = DATA_W'(shift);
      reg_value[REG_OUT_OFFSET]  = offset;
      reg_value[REG_RELU_ENABLE] = DATA_W'(relu);
      for (int i = 0; i < REG_COUNT; i++)
         csr_write(reg_index_type'(i), reg_value[i]);
      model_cfg.scale_mult  = mult;
      model_cfg.scale_shift = shift;
      model_cfg.out_offset  = offset;
      model_cfg.relu_enable = relu;
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_read(reg_index_type'(i), got);
         if (got !== reg_value[i]) begin
            mismatches++;
            $display("%0t: csr readback at index %0d expected %h got %h",
                     $time, i, reg_value[i], got);
         end
      end
      settings_applied++;
   endtask

   // stimulus and end of run
   initial begin
      int                  phase_pairs;
      int                  vec_len;
      logic [WORD_W-1:0]   mult;
      logic [SHIFT_W-1:0]  shift;
      logic [WORD_W-1:0]   offset;
      logic [WORD_W-1:0]   bias;

      // every input known from time zero
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_if.valid       = 1'b0;
      req_if.activation  = '0;
      req_if.weight      = '0;
      req_if.bias        = '0;
      req_if.last_pair   = 1'b0;
      rsp_if.ready       = 1'b0;
      model_cfg          = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // unity scale, plain clamp
      apply_settings(32'sd1, 6'd0, 32'sd0, 1'b0);
      add_pair(-8'sd128, -8'sd128, 32'd0, 1'b1);            // largest product, clamps high
      add_pair(8'sd127, -8'sd128, 32'd0, 1'b1);             // most negative product, clamps low
      add_pair(8'sd127, 8'sd127, -32'sd16129, 1'b1);        // bias cancels the product
      add_pair(8'sd5, 8'sd3, 32'hdead_beef, 1'b0);          // bias ignored when not last
      add_pair(-8'sd2, 8'sd7, 32'sd100, 1'b1);
      add_pair(8'sd1, 8'sd1, 32'h7fff_ffff, 1'b1);          // bias add wraps negative
      add_pair(-8'sd1, 8'sd1, 32'h8000_0000, 1'b1);         // bias add wraps positive
      add_pair(8'sd0, -8'sd128, -32'sd5, 1'b1);

      // relu ahead of a small offset
      apply_settings(32'sd1, 6'd0, 32'sd5, 1'b1);
      add_pair(-8'sd100, 8'sd100, 32'd0, 1'b1);             // negative forced to zero
      add_pair(8'sd10, 8'sd10, 32'd0, 1'b1);
      add_pair(8'sd3, 8'sd4, 32'hffff_ffff, 1'b0);
      add_pair(8'sd1, 8'sd1, 32'sd20, 1'b1);

      // most negative multiplier, full shift leaves 0 or -1
      apply_settings(32'h8000_0000, 6'd63, 32'sd0, 1'b0);
      add_pair(-8'sd128, -8'sd128, 32'd0, 1'b1);
      add_pair(8'sd127, 8'sd127, -32'sd16129, 1'b1);
      add_pair(-8'sd128, 8'sd127, 32'h8000_0000, 1'b1);

      // no shift: only the low word survives, huge offset added without wrap
      apply_settings(32'h7fff_ffff, 6'd0, 32'h7fff_ffff, 1'b0);
      add_pair(8'sd127, 8'sd127, 32'd0, 1'b1);
      add_pair(-8'sd128, 8'sd1, 32'h7fff_ff80, 1'b1);
      add_pair(8'sd1, 8'sd0, 32'h8000_0000, 1'b1);

      // most negative offset with relu on
      apply_settings(32'h7fff_ffff, 6'd16, 32'h8000_0000, 1'b1);
      add_pair(8'sd127, -8'sd128, 32'd0, 1'b1);
      add_pair(8'sd127, 8'sd127, 32'h7fff_ffff, 1'b1);

      // random settings, each followed by a run of random neurons
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0: mult = 32'h8000_0000;
            1: mult = 32'h7fff_ffff;
            2: mult = '0;
            default: mult = $urandom;
         endcase
         // shifts that keep typical sums inside the output range, plus any value
         shift  = ($urandom_range(0, 9) < 7) ? SHIFT_W'($urandom_range(36, 52))
                                             : SHIFT_W'($urandom_range(0, 63));
         offset = ($urandom_range(0, 3) != 0) ? WORD_W'($urandom_range(0, 128) - 64)
                                              : WORD_W'($urandom);
         apply_settings(mult, shift, offset, 1'($urandom_range(0, 1)));

         phase_pairs = 0;
         while (phase_pairs < PHASE_PAIRS) begin
            vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < vec_len; k++) begin
               if (k != vec_len - 1)
                  bias = $urandom;                   // ignored, still toggled
               else if ($urandom_range(0, 3) == 0)
                  bias = $urandom;                   // full range, often wraps
               else
                  bias = WORD_W'($urandom_range(0, 65536) - 32768);
               add_pair(pick_int8(), pick_int8(), bias, k == vec_len - 1);
            end
            phase_pairs += vec_len;
         end
      end

      wait_idle();
      if (neuron_outputs_due.size() != 0) begin
         mismatches++;
         $display("%0t: %0d neuron outputs never arrived", $time, neuron_outputs_due.size());
      end
      $display("covered %0d pairs and %0d neuron outputs over %0d register settings",
               pairs_accepted, outputs_checked, settings_applied);
      $display("output side held off %0d times for %0d cycles each", long_holds, HOLD_CYCLES);
      if (mismatches == 0)
         $display("PASS int8_dot_product_requantize");
      else
         $display("FAIL int8_dot_product_requantize");
      $finish;
   end

   // driver: offers pairs in bursts, predicts each transfer as it happens
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         pair_on_bus = 1'b0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         // transfer on the request side
         if (pair_on_bus && req_if.ready) begin
            mac_step(bus_pair);
            pairs_accepted++;
            pair_on_bus = 1'b0;
         end
         if (!pair_on_bus) begin
            if (gap_left > 0)
               gap_left--;
            else if (pairs_to_send.size() != 0) begin
               bus_pair = pairs_to_send.pop_front();
               pair_on_bus = 1'b1;
               req_if.activation <= bus_pair.activation;
               req_if.weight     <= bus_pair.weight;
               req_if.bias       <= bus_pair.bias;
               req_if.last_pair  <= bus_pair.last_pair;
               // end of burst: pick a gap and the next burst length
               if (burst_left > 1)
                  burst_left--;
               else begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 12);
                  gap_left   = $urandom_range(1, 6);
               end
            end
         end
         // valid stays high while a pair waits, lowered only in a gap or with no pair queued
         req_if.valid <= pair_on_bus;
      end
   end

   // monitor: checks each result transfer and drives the output stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (neuron_outputs_due.size() == 0) begin
               mismatches++;
               $display("%0t: result %0d with no neuron output pending",
                        $time, $signed(rsp_if.result));
            end else begin
               output_wanted = neuron_outputs_due.pop_front();
               if (rsp_if.result !== output_wanted) begin
                  mismatches++;
                  $display("%0t: result mismatch expected %0d got %0d",
                           $time, output_wanted, $signed(rsp_if.result));
               end
            end
            outputs_checked++;
            // long hold-off twice during the random part, input keeps streaming
            if (outputs_checked == 50 || outputs_checked == 110) begin
               hold_left = HOLD_CYCLES;
               long_holds++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            sink_take = 1'b0;
         end else begin
            if (mode_left == 0) begin
               sink_mode = sink_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(16, 96);
            end else
               mode_left--;
            case (sink_mode)
               SINK_OPEN:   sink_take = 1'b1;
               SINK_RANDOM: sink_take = ($urandom_range(0, 1) == 1);
               default:     sink_take = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_if.ready <= sink_take;
      end
   end

   // watchdog: too long without a transfer on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL int8_dot_product_requantize");
         $finish;
      end
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/dpr_pkg.sv
rtl/dpr_req_if.sv
rtl/dpr_rsp_if.sv
rtl/dpr_alu.sv
rtl/dpr_csr.sv
rtl/int8_dot_product_requantize.sv
tb/tb_int8_dot_product_requantize.sv
